>>> rtl/core/key_event_detector_macros.svh
// Assertion macros for the key event detector RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef KEY_EVENT_DETECTOR_MACROS_SVH
`define KEY_EVENT_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check that is switched off while reset is asserted.
`define KED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define KED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KED_ASSERT(lbl, clk, rst_n, prop, msg)
`define KED_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/ked_pkg.sv
package ked_pkg;

  // Field widths.
  localparam int KEY_W     = 8;
  localparam int CNT_W     = 8;
  localparam int ACT_W     = 6;
  localparam int EV_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 8;

  // Key code reported by the scanner when nothing is pressed.
  localparam logic [KEY_W-1:0] NO_KEY_CODE   = 8'd255;
  // Activity counter reload value on any press.
  localparam logic [ACT_W-1:0] ACTIVE_RELOAD = 6'd35;
  // Saturation limit of the press, click and release gap counters.
  localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;

  // Configuration register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 8'd2;
  localparam logic [CFG_W-1:0] LONG_RST      = 8'd75;
  localparam logic [CFG_W-1:0] HOLD_RST      = 8'd90;
  localparam logic [CFG_W-1:0] CLICK_GAP_RST = 8'd20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_GAP = 3'd3;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 3'd0,
    EV_CLICK = 3'd1,
    EV_LONG  = 3'd2,
    EV_HOLD  = 3'd3,
    EV_UP    = 3'd4
  } ked_event_e;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_samples;
    logic [CFG_W-1:0] long_press_samples;
    logic [CFG_W-1:0] hold_press_samples;
    logic [CFG_W-1:0] click_gap_samples;
  } ked_cfg_t;

  typedef struct packed {
    ked_event_e       event_code;
    logic [KEY_W-1:0] event_key;
    logic             key_active;
  } ked_result_t;

endpackage

>>> rtl/core/ked_if.sv
// Scan sample channel.
interface ked_key_if
  import ked_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

// Key event channel.
interface ked_evt_if
  import ked_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  event_code;
  logic [KEY_W-1:0] event_key;
  logic             key_active;

  modport source (output valid, output event_code, output event_key, output key_active,
                  input ready);
  modport sink (input valid, input event_code, input event_key, input key_active,
                output ready);
endinterface

// Configuration write channel.
interface ked_cfg_if
  import ked_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/ked_cfg_regs.sv
module ked_cfg_regs
  import ked_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ked_cfg_if.sink      cfg_in,
  output ked_cfg_t     cfg_o
);

  ked_cfg_t cfg_q;

  // Writes are always taken; an index beyond the register list is dropped.
  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_samples   <= DEBOUNCE_RST;
      cfg_q.long_press_samples <= LONG_RST;
      cfg_q.hold_press_samples <= HOLD_RST;
      cfg_q.click_gap_samples  <= CLICK_GAP_RST;
    end else if (cfg_in.valid) begin
      unique case (cfg_in.index)
        CFG_DEBOUNCE:  cfg_q.debounce_samples   <= cfg_in.data;
        CFG_LONG:      cfg_q.long_press_samples <= cfg_in.data;
        CFG_HOLD:      cfg_q.hold_press_samples <= cfg_in.data;
        CFG_CLICK_GAP: cfg_q.click_gap_samples  <= cfg_in.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/ked_in_reg.sv
module ked_in_reg
  import ked_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ked_key_if.sink          key_in,
  // The engine consumes the held sample this cycle.
  input  logic             step_i,
  output logic             valid_o,
  output logic [KEY_W-1:0] key_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q;
  logic             take;

  // A new request is taken when the register is empty or drains this cycle.
  assign key_in.ready = !valid_q || step_i;
  assign take         = key_in.valid && key_in.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q <= key_in.key_code;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

>>> rtl/core/ked_engine.sv
module ked_engine
  import ked_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ked_cfg_t         cfg_i,
  input  logic             step_i,
  input  logic [KEY_W-1:0] key_i,
  output ked_result_t      result_o
);

  logic [KEY_W-1:0] db_value_q, db_value_d;
  logic [CNT_W-1:0] db_count_q, db_count_d;
  logic [KEY_W-1:0] prev_key_q, prev_key_d;
  logic [CNT_W-1:0] press_q, press_d;
  logic [CNT_W-1:0] click_q, click_d;
  logic [CNT_W-1:0] gap_q, gap_d;
  logic [KEY_W-1:0] pending_q, pending_d;
  logic [ACT_W-1:0] act_q, act_d;

  logic             idle;
  logic [CNT_W-1:0] press_inc;
  ked_event_e       code;
  logic [KEY_W-1:0] ekey;

  assign idle = (key_i == NO_KEY_CODE);

  // Press count after the saturating increment of a held key.
  assign press_inc = (press_q < CNT_MAX) ? press_q + 1'b1 : press_q;

  // Next state and event for the sample held in the input register.
  always_comb begin
    db_value_d = db_value_q;
    db_count_d = db_count_q;
    prev_key_d = prev_key_q;
    press_d    = press_q;
    click_d    = click_q;
    gap_d      = gap_q;
    pending_d  = pending_q;
    code       = EV_NONE;
    ekey       = NO_KEY_CODE;

    // Activity counter reloads on a press and runs down while idle.
    if (!idle) begin
      act_d = ACTIVE_RELOAD;
    end else if (act_q != '0) begin
      act_d = act_q - 1'b1;
    end else begin
      act_d = act_q;
    end

    if (key_i != db_value_q && cfg_i.debounce_samples != '0) begin
      // The sample differs from the debounced value: restart the filter.
      db_count_d = '0;
      db_value_d = key_i;
    end else if (db_count_q < cfg_i.debounce_samples) begin
      // Still settling.
      db_count_d = db_count_q + 1'b1;
    end else begin
      if (key_i != prev_key_q) begin
        if (idle) begin
          // Release edge.
          if (press_q >= cfg_i.long_press_samples) begin
            code = EV_UP;
            ekey = prev_key_q;
          end else begin
            gap_d = 8'd1;
          end
        end else begin
          // Press edge; repeated presses of the same key add to the click count.
          press_d = 8'd1;
          if (key_i != pending_q) begin
            click_d   = 8'd1;
            pending_d = key_i;
          end else if (click_q < CNT_MAX) begin
            click_d = click_q + 1'b1;
          end
        end
      end else if (idle) begin
        // Released and waiting for the click gap to run out.
        if (click_q != '0) begin
          if (gap_q > cfg_i.click_gap_samples) begin
            code = EV_CLICK;
            ekey = pending_q;
          end else if (gap_q < CNT_MAX) begin
            gap_d = gap_q + 1'b1;
          end
        end
      end else begin
        // Key held: long once, then hold repeatedly.
        press_d = press_inc;
        if (press_inc == cfg_i.long_press_samples) begin
          code = EV_LONG;
          ekey = key_i;
        end else if (press_inc == cfg_i.hold_press_samples) begin
          code    = EV_HOLD;
          ekey    = key_i;
          press_d = cfg_i.long_press_samples;
        end
      end

      if (code != EV_NONE) begin
        click_d   = '0;
        pending_d = NO_KEY_CODE;
      end
      prev_key_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_value_q <= NO_KEY_CODE;
      db_count_q <= '0;
      prev_key_q <= NO_KEY_CODE;
      press_q    <= '0;
      click_q    <= '0;
      gap_q      <= '0;
      pending_q  <= NO_KEY_CODE;
      act_q      <= '0;
    end else if (step_i) begin
      db_value_q <= db_value_d;
      db_count_q <= db_count_d;
      prev_key_q <= prev_key_d;
      press_q    <= press_d;
      click_q    <= click_d;
      gap_q      <= gap_d;
      pending_q  <= pending_d;
      act_q      <= act_d;
    end
  end

  assign result_o.event_code = code;
  assign result_o.event_key  = ekey;
  assign result_o.key_active = (act_d != '0);

endmodule

>>> rtl/core/key_event_detector.sv
// Debounced keypad event detector. Each request on key_in is one scan sample
// (a key code, or the no-key code 255); each sample yields exactly one event
// on evt_out: none, click, long, hold or up, with the key it refers to and a
// flag that is high on a pressed sample and on the 34 samples after the last
// press. The block takes one sample per clock cycle when the output side keeps
// up. A sample is held in the input register, the whole counter update is
// combinational between the input and result registers, and its event is
// shown on evt_out from the result register. When evt_out stalls, one sample
// waits in each register and key_in is held off. The user is to write the
// configuration registers through cfg_in only while no sample is in flight;
// the block itself does not enforce this.
`include "key_event_detector_macros.svh"

module key_event_detector
  import ked_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  ked_key_if.sink   key_in,
  ked_evt_if.source evt_out,
  ked_cfg_if.sink   cfg_in
);

  ked_cfg_t         cfg;
  logic             in_valid;
  logic [KEY_W-1:0] in_key;
  logic             step;
  ked_result_t      result;

  logic             out_valid_q, out_valid_d;
  ked_result_t      out_q;

  ked_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_in (cfg_in),
    .cfg_o  (cfg)
  );

  ked_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_in  (key_in),
    .step_i  (step),
    .valid_o (in_valid),
    .key_o   (in_key)
  );

  ked_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .key_i    (in_key),
    .result_o (result)
  );

  // The held sample is processed when the result register is free or drains.
  assign step = in_valid && (!out_valid_q || evt_out.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (evt_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign evt_out.valid      = out_valid_q;
  assign evt_out.event_code = out_q.event_code;
  assign evt_out.event_key  = out_q.event_key;
  assign evt_out.key_active = out_q.key_active;

  // A processed sample always lands in the result register.
  `KED_ASSERT(a_step_fills_out, clk_i, rst_ni, step |=> out_valid_q, "result lost after step")
  // A sample waiting on a stalled output keeps its key.
  `KED_ASSERT(a_in_held, clk_i, rst_ni, in_valid && !step |=> in_valid && $stable(in_key), "input sample dropped while stalled")
  // A pressed key always shows as active in its own result.
  `KED_ASSERT(a_press_active, clk_i, rst_ni, step && in_key != NO_KEY_CODE |=> out_q.key_active, "press not flagged as active")
  // An event names a real key, and no event names none.
  `KED_ASSERT(a_event_key, clk_i, rst_ni, out_valid_q |-> ((out_q.event_code == EV_NONE) == (out_q.event_key == NO_KEY_CODE)), "event key inconsistent with event code")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ked_pkg::*;

  // Scan samples to send in all, directed part included.
  localparam int unsigned TOTAL_SCANS = 1670;
  // Number of register slots the index field can address.
  localparam int unsigned CFG_SLOTS   = 1 << CFG_IDX_W;
  // Key used for the counter saturation sequence.
  localparam logic [KEY_W-1:0] TAP_KEY = 8'h42;

  // Tracks the detector's counters and holds the events it must report.
  class key_event_tracker;
    ked_cfg_t         regs;
    logic [KEY_W-1:0] stable_key;
    logic [CNT_W-1:0] stable_cnt;
    logic [KEY_W-1:0] prior_key;
    logic [CNT_W-1:0] held_cnt;
    logic [CNT_W-1:0] tap_cnt;
    logic [CNT_W-1:0] gap_cnt;
    logic [KEY_W-1:0] click_key;
    logic [ACT_W-1:0] active_cnt;
    ked_result_t      expected_events[$];
    int unsigned      error_count;

    function new();
      regs.debounce_samples   = DEBOUNCE_RST;
      regs.long_press_samples = LONG_RST;
      regs.hold_press_samples = HOLD_RST;
      regs.click_gap_samples  = CLICK_GAP_RST;
      stable_key  = NO_KEY_CODE;
      stable_cnt  = '0;
      prior_key   = NO_KEY_CODE;
      held_cnt    = '0;
      tap_cnt     = '0;
      gap_cnt     = '0;
      click_key   = NO_KEY_CODE;
      active_cnt  = '0;
      error_count = 0;
    endfunction

    // Unknown indexes are silently dropped by the block.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_DEBOUNCE:  regs.debounce_samples   = value;
        CFG_LONG:      regs.long_press_samples = value;
        CFG_HOLD:      regs.hold_press_samples = value;
        CFG_CLICK_GAP: regs.click_gap_samples  = value;
        default: ;
      endcase
    endfunction

    // Works out the event caused by one accepted scan sample.
    function void take_scan(logic [KEY_W-1:0] key);
      ked_result_t res;
      logic        idle;
      idle          = (key == NO_KEY_CODE);
      res.event_code = EV_NONE;
      res.event_key  = NO_KEY_CODE;

      // Activity counter reloads on any press and runs down while idle.
      if (!idle) begin
        active_cnt = ACTIVE_RELOAD;
      end else if (active_cnt != 0) begin
        active_cnt = active_cnt - 1'b1;
      end

      // A change restarts the debounce window; samples inside it are dropped.
      if (key != stable_key && regs.debounce_samples != 0) begin
        stable_cnt = '0;
        stable_key = key;
      end else if (stable_cnt < regs.debounce_samples) begin
        stable_cnt = stable_cnt + 1'b1;
      end else begin
        if (key != prior_key) begin
          // Edge: release ends a press, a new key starts one.
          if (idle) begin
            if (held_cnt >= regs.long_press_samples) begin
              res.event_code = EV_UP;
              res.event_key  = prior_key;
            end else begin
              gap_cnt = 8'd1;
            end
          end else begin
            held_cnt = 8'd1;
            if (key != click_key) begin
              tap_cnt   = 8'd1;
              click_key = key;
            end else if (tap_cnt < CNT_MAX) begin
              tap_cnt = tap_cnt + 1'b1;
            end
          end
        end else if (idle) begin
          // Released and stable: a click is due once the gap is long enough.
          if (tap_cnt > 0) begin
            if (gap_cnt > regs.click_gap_samples) begin
              res.event_code = EV_CLICK;
              res.event_key  = click_key;
            end else if (gap_cnt < CNT_MAX) begin
              gap_cnt = gap_cnt + 1'b1;
            end
          end
        end else begin
          // Held: long at the long threshold, hold repeats from the hold one.
          if (held_cnt < CNT_MAX) begin
            held_cnt = held_cnt + 1'b1;
          end
          if (held_cnt == regs.long_press_samples) begin
            res.event_code = EV_LONG;
            res.event_key  = key;
          end else if (held_cnt == regs.hold_press_samples) begin
            res.event_code = EV_HOLD;
            res.event_key  = key;
            held_cnt       = regs.long_press_samples;
          end
        end
        if (res.event_code != EV_NONE) begin
          tap_cnt   = '0;
          click_key = NO_KEY_CODE;
        end
        prior_key = key;
      end

      res.key_active = (active_cnt != 0);
      expected_events.push_back(res);
    endfunction

    // Compares a reported event with the oldest one still owed.
    function void match_event(logic [EV_W-1:0] code, logic [KEY_W-1:0] key, logic active);
      ked_result_t exp;
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_code %0d, event_key %0d, key_active %0b",
               code, key, active);
        error_count++;
      end else begin
        exp = expected_events.pop_front();
        if (code !== exp.event_code) begin
          $error("event_code: expected %0d, got %0d", exp.event_code, code);
          error_count++;
        end
        if (key !== exp.event_key) begin
          $error("event_key: expected %0d, got %0d", exp.event_key, key);
          error_count++;
        end
        if (active !== exp.key_active) begin
          $error("key_active: expected %0b, got %0b", exp.key_active, active);
          error_count++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ked_key_if key_ch ();
  ked_evt_if evt_ch ();
  ked_cfg_if cfg_ch ();

  key_event_tracker tracker = new();

  int unsigned sent_count      = 0;
  int unsigned send_idle_pct   = 9;
  int unsigned recv_stall_pct  = 62;
  bit          long_hold_req   = 1'b0;
  bit          long_hold_done  = 1'b0;
  bit          saturation_done = 1'b0;

  key_event_detector dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .key_in  (key_ch),
    .evt_out (evt_ch),
    .cfg_in  (cfg_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Traffic profile follows progress: heavy receiver stalls, then heavy sender idles, then none.
  function automatic void update_traffic();
    if (sent_count < TOTAL_SCANS / 3) begin
      send_idle_pct  = 9;
      recv_stall_pct = 62;
    end else if (sent_count < 2 * TOTAL_SCANS / 3) begin
      send_idle_pct  = 62;
      recv_stall_pct = 9;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      if (!long_hold_done) begin
        long_hold_req  = 1'b1;
        long_hold_done = 1'b1;
      end
    end
  endfunction

  // Offers one scan sample and waits for the request to be taken.
  task automatic send_scan(input logic [KEY_W-1:0] key);
    update_traffic();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_code <= key;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    tracker.take_scan(key);
    sent_count++;
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_reg(idx, value);
  endtask

  // Drains the pipeline, then writes every register and maybe a dead slot.
  task automatic configure(input ked_cfg_t c, input bit hit_unused);
    key_ch.valid <= 1'b0;
    while (tracker.expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(CFG_DEBOUNCE, c.debounce_samples);
    write_reg(CFG_LONG, c.long_press_samples);
    write_reg(CFG_HOLD, c.hold_press_samples);
    write_reg(CFG_CLICK_GAP, c.click_gap_samples);
    if (hit_unused) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_CLICK_GAP + 1, CFG_SLOTS - 1)),
                CFG_W'($urandom_range(0, 255)));
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Thresholds are mostly small so events come often, with the extremes mixed in.
  function automatic logic [CFG_W-1:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return CNT_MAX;
    end else if (r == 2) begin
      return CFG_W'($urandom_range(0, 255));
    end
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // Well-formed presses and releases with bounce, glitches and noise bursts.
  task automatic random_phase();
    ked_cfg_t         c;
    logic [KEY_W-1:0] favourites[4];
    logic [KEY_W-1:0] key;
    int unsigned      stop_at;
    int unsigned      press_max;
    int unsigned      release_max;
    int unsigned      press_len;
    c.debounce_samples   = ($urandom_range(0, 5) == 0) ? pick_threshold()
                                                       : CFG_W'($urandom_range(0, 3));
    c.long_press_samples = pick_threshold();
    c.hold_press_samples = pick_threshold();
    c.click_gap_samples  = pick_threshold();
    configure(c, $urandom_range(0, 3) == 0);
    foreach (favourites[i]) favourites[i] = KEY_W'($urandom_range(0, NO_KEY_CODE - 1));
    press_max = c.debounce_samples + ((c.long_press_samples > c.hold_press_samples) ?
                c.long_press_samples : c.hold_press_samples) + 3;
    if (press_max > 48) press_max = 48;
    release_max = c.debounce_samples + c.click_gap_samples + 4;
    if (release_max > 48) release_max = 48;
    stop_at = sent_count + $urandom_range(60, 140);

    while (sent_count < stop_at) begin
      key = ($urandom_range(0, 9) < 7) ? favourites[$urandom_range(0, 3)]
                                       : KEY_W'($urandom_range(0, NO_KEY_CODE - 1));
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_scan(KEY_W'($urandom_range(0, NO_KEY_CODE)));
      end
      // Contact bounce ahead of the press.
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) send_scan(KEY_W'($urandom_range(0, NO_KEY_CODE)));
      end
      press_len = ($urandom_range(0, 99) < 3) ? 260 : $urandom_range(1, press_max);
      repeat (press_len) begin
        if ($urandom_range(0, 99) < 4) begin
          send_scan(KEY_W'($urandom_range(0, NO_KEY_CODE)));
        end else begin
          send_scan(key);
        end
      end
      repeat ($urandom_range(1, release_max)) send_scan(NO_KEY_CODE);
    end
  endtask

  // Drives the click, release gap and press counters into saturation.
  task automatic saturation_phase();
    ked_cfg_t c;
    c.debounce_samples   = '0;
    c.long_press_samples = CNT_MAX;
    c.hold_press_samples = CNT_MAX;
    c.click_gap_samples  = CNT_MAX;
    configure(c, 1'b0);
    repeat (258) begin
      send_scan(TAP_KEY);
      send_scan(NO_KEY_CODE);
    end
    repeat (258) send_scan(NO_KEY_CODE);
    repeat (258) send_scan(TAP_KEY);
    send_scan(NO_KEY_CODE);
    saturation_done = 1'b1;
  endtask

  // Event side: checks every accepted result and throttles ready.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    evt_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (evt_ch.valid && evt_ch.ready) begin
        tracker.match_event(evt_ch.event_code, evt_ch.event_key, evt_ch.key_active);
      end
      // One long hold-off lets the block fill up and stall its input.
      if (long_hold_req) begin
        hold_left     = 60;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    ked_cfg_t    c;
    int unsigned waited;
    rst_n           = 1'b0;
    key_ch.valid    = 1'b0;
    key_ch.key_code = NO_KEY_CODE;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_DEBOUNCE;
    cfg_ch.data     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset thresholds: the first samples of a press are held back by debounce.
    repeat (4) send_scan(8'h00);
    repeat (2) send_scan(NO_KEY_CODE);

    // Debounce off, tight thresholds: click, long, repeated hold, up, key swap.
    c.debounce_samples   = '0;
    c.long_press_samples = 8'd2;
    c.hold_press_samples = 8'd3;
    c.click_gap_samples  = 8'd1;
    configure(c, 1'b0);
    send_scan(8'hFE);
    repeat (3) send_scan(NO_KEY_CODE);
    repeat (4) send_scan(8'h5A);
    send_scan(NO_KEY_CODE);
    send_scan(8'h01);
    send_scan(8'h80);
    send_scan(NO_KEY_CODE);

    // A zero long threshold turns every release into an up event.
    c.long_press_samples = '0;
    configure(c, 1'b1);
    send_scan(8'h33);
    send_scan(NO_KEY_CODE);

    while (sent_count < TOTAL_SCANS) begin
      if (!saturation_done && sent_count >= 400) begin
        saturation_phase();
      end else begin
        random_phase();
      end
    end

    // Wait for the last events, then give the pipeline time to misbehave.
    key_ch.valid <= 1'b0;
    waited = 0;
    while (tracker.expected_events.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (tracker.expected_events.size() != 0) begin
      $error("%0d expected events never arrived", tracker.expected_events.size());
      tracker.error_count++;
    end
    if (tracker.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ked_pkg.sv
rtl/core/ked_if.sv
rtl/core/ked_cfg_regs.sv
rtl/core/ked_in_reg.sv
rtl/core/ked_engine.sv
rtl/core/key_event_detector.sv
verif/testbench.sv
